// ===== src/gn_pkg.sv =====
// shared types, request codes and widths for the gradient noise unit
package gn_pkg;

    // lattice size and its index width
    localparam int TABLE_SIZE = 256;
    localparam int IW         = $clog2(TABLE_SIZE);

    // width of dot products and blended values
    localparam int VW = 20;

    // request codes
    localparam logic [2:0] REQ_LOAD_PERM = 3'd0;
    localparam logic [2:0] REQ_LOAD_G1   = 3'd1;
    localparam logic [2:0] REQ_LOAD_G2   = 3'd2;
    localparam logic [2:0] REQ_LOAD_G3   = 3'd3;
    localparam logic [2:0] REQ_EVAL1     = 3'd4;
    localparam logic [2:0] REQ_EVAL2     = 3'd5;
    localparam logic [2:0] REQ_EVAL3     = 3'd6;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [7:0]         table_index;
        logic [7:0]         perm_value;
        logic signed [15:0] grad_x;
        logic signed [15:0] grad_y;
        logic signed [15:0] grad_z;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] noise_value;
        logic               is_noise;
    } out_word_t;

    // per-stage control travelling with each word
    typedef struct packed {
        logic       valid;
        logic [2:0] req_type;
    } ctl_t;

endpackage

// ===== src/gradient_noise_1d_2d_3d_unit.sv =====
// top level of the gradient noise unit: handshake, pipeline and output register
//
//   channel | dir | handshake            | word
//   req     | in  | req_valid/req_stall  | gn_pkg::in_word_t
//   rsp     | out | rsp_valid/rsp_stall  | gn_pkg::out_word_t
//
// one word enters per cycle unless a held result stalls the pipeline.
// the pipeline length is set by three table memory levels and the multiply/add stages.
// tables are written in the pipeline stage that reads them, so order is kept.
// a stalled result freezes the whole pipeline; no clearing pass after reset.
module gradient_noise_1d_2d_3d_unit #(
    parameter int COORD_FRAC_BITS = 16,
    parameter int GRAD_FRAC_BITS  = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  gn_pkg::in_word_t  req_word,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output gn_pkg::out_word_t rsp_word
);
    import gn_pkg::*;

    localparam int F  = COORD_FRAC_BITS;
    localparam int SL = (GRAD_FRAC_BITS < 14) ? 14 - GRAD_FRAC_BITS : 0;
    localparam int SR = (GRAD_FRAC_BITS > 14) ? GRAD_FRAC_BITS - 14 : 0;
    localparam int WW = VW + 8;

    logic                 adv;
    logic                 take;
    ctl_t                 ctl_mid, ctl_end;
    logic [2:0][F-1:0]    frac;
    logic [2:0][F:0]      curve;
    logic [1:0][15:0]     g1;
    logic [3:0][31:0]     g2;
    logic [7:0][47:0]     g3;
    logic signed [VW-1:0] value;
    logic signed [WW-1:0] wide;
    logic                 eval;

    logic                 rsp_valid_reg;
    out_word_t            rsp_word_reg, rsp_word_next;

    // pipeline moves unless a finished result is held
    assign adv       = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !adv;
    assign take      = req_valid && adv;

    gn_lookup #(.COORD_FRAC_BITS(F)) u_lookup (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .take     (take),
        .req_word (req_word),
        .ctl      (ctl_mid),
        .frac     (frac),
        .curve    (curve),
        .g1       (g1),
        .g2       (g2),
        .g3       (g3)
    );

    gn_blend #(.COORD_FRAC_BITS(F)) u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .ctl     (ctl_mid),
        .frac    (frac),
        .curve   (curve),
        .g1      (g1),
        .g2      (g2),
        .g3      (g3),
        .ctl_out (ctl_end),
        .value   (value)
    );

    // rescale to q2.14 and saturate; words that are not evaluations give zero
    always_comb
    begin
        wide = WW'(value);
        wide = (wide <<< SL) >>> SR;
        eval = ctl_end.req_type == REQ_EVAL1 || ctl_end.req_type == REQ_EVAL2 ||
               ctl_end.req_type == REQ_EVAL3;
        rsp_word_next.is_noise = eval;
        if (!eval)
        begin
            rsp_word_next.noise_value = '0;
        end
        else if (wide > WW'(32767))
        begin
            rsp_word_next.noise_value = 16'sd32767;
        end
        else if (wide < -WW'(32768))
        begin
            rsp_word_next.noise_value = -16'sd32768;
        end
        else
        begin
            rsp_word_next.noise_value = wide[15:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= ctl_end.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

// ===== src/gn_ram.sv =====
// table memory: one write port, two registered read ports
module gn_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [2**AW];

    // read old contents, write in the same edge
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[waddr] <= wdata;
            end
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== src/gn_lookup.sv =====
// hash front end: lattice cells, permutation lookups, gradient fetch, s-curves
module gn_lookup #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                take,
    input  gn_pkg::in_word_t                    req_word,
    output gn_pkg::ctl_t                        ctl,
    output logic [2:0][COORD_FRAC_BITS-1:0]     frac,
    output logic [2:0][COORD_FRAC_BITS:0]       curve,
    output logic [1:0][15:0]                    g1,
    output logic [3:0][31:0]                    g2,
    output logic [7:0][47:0]                    g3
);
    import gn_pkg::*;

    localparam int F = COORD_FRAC_BITS;

    ctl_t c1_reg, c2_reg, c3_reg, c4_reg;

    logic [IW-1:0]          ti1_reg, ti2_reg, ti3_reg;
    logic [7:0]             pv1_reg, pv2_reg;
    logic [2:0][15:0]       gr1_reg, gr2_reg, gr3_reg;
    logic [2:0][IW-1:0]     cell1_reg;
    logic [2:1][IW-1:0]     cell2_reg;
    logic [IW-1:0]          zc3_reg;
    logic [2:0][F-1:0]      fr1_reg, fr2_reg, fr3_reg, fr4_reg;
    logic [2:0][F-1:0]      q2_reg;
    logic [2:0][F:0]        s3_reg, s4_reg;
    logic [1:0][15:0]       g1_reg;

    logic [2:0][IW-1:0]     cell_in;
    logic [2:0][F-1:0]      fr_in;
    logic [2:0][F-1:0]      q_next;
    logic [2:0][F:0]        s_next;
    logic [2*F-1:0]         sq_prod [3];
    logic [F+1:0]           fac [3];
    logic [2*F+1:0]         s_prod [3];

    logic [IW-1:0]          pi, pj;
    logic [1:0][1:0][IW-1:0] hy;
    logic [1:0][IW-1:0]     zc;
    logic [1:0][15:0]       g1_rd;

    // cell index and fraction from the raw coordinates
    always_comb
    begin
        cell_in[0] = req_word.coord_x[F+IW-1:F];
        cell_in[1] = req_word.coord_y[F+IW-1:F];
        cell_in[2] = req_word.coord_z[F+IW-1:F];
        fr_in[0]   = req_word.coord_x[F-1:0];
        fr_in[1]   = req_word.coord_y[F-1:0];
        fr_in[2]   = req_word.coord_z[F-1:0];
    end

    // s-curve pieces: r^2 in stage 1, times (3 - 2r) in stage 2
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            sq_prod[a] = fr1_reg[a] * fr1_reg[a];
            q_next[a]  = sq_prod[a][2*F-1:F];
            fac[a]     = {2'b11, {F{1'b0}}} - {1'b0, fr2_reg[a], 1'b0};
            s_prod[a]  = q2_reg[a] * fac[a];
            s_next[a]  = s_prod[a][2*F:F];
        end
    end

    // control line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
        end
        else if (adv)
        begin
            c1_reg <= '{valid: take, req_type: req_word.req_type};
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            c4_reg <= c3_reg;
        end
    end

    // payload line
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ti1_reg   <= req_word.table_index[IW-1:0];
            pv1_reg   <= req_word.perm_value;
            gr1_reg   <= {req_word.grad_z, req_word.grad_y, req_word.grad_x};
            cell1_reg <= cell_in;
            fr1_reg   <= fr_in;

            ti2_reg   <= ti1_reg;
            pv2_reg   <= pv1_reg;
            gr2_reg   <= gr1_reg;
            cell2_reg <= cell1_reg[2:1];
            fr2_reg   <= fr1_reg;
            q2_reg    <= q_next;

            ti3_reg   <= ti2_reg;
            gr3_reg   <= gr2_reg;
            zc3_reg   <= cell2_reg[2];
            fr3_reg   <= fr2_reg;
            s3_reg    <= s_next;

            fr4_reg   <= fr3_reg;
            s4_reg    <= s3_reg;
            g1_reg    <= g1_rd;
        end
    end

    // stage 1: first permutation level on the x cells
    gn_ram #(.AW(IW), .DW(IW)) u_perm_a (
        .clk     (clk),
        .en      (adv),
        .we      (c1_reg.valid && c1_reg.req_type == REQ_LOAD_PERM),
        .waddr   (ti1_reg),
        .wdata   (pv1_reg[IW-1:0]),
        .raddr_a (cell1_reg[0]),
        .raddr_b (cell1_reg[0] + IW'(1)),
        .rdata_a (pi),
        .rdata_b (pj)
    );

    // stage 2: second permutation level, one copy for each y corner
    for (genvar gy = 0; gy < 2; gy++)
    begin : g_perm_b
        gn_ram #(.AW(IW), .DW(IW)) u_perm_b (
            .clk     (clk),
            .en      (adv),
            .we      (c2_reg.valid && c2_reg.req_type == REQ_LOAD_PERM),
            .waddr   (ti2_reg),
            .wdata   (pv2_reg[IW-1:0]),
            .raddr_a (pi + cell2_reg[1] + IW'(gy)),
            .raddr_b (pj + cell2_reg[1] + IW'(gy)),
            .rdata_a (hy[gy][0]),
            .rdata_b (hy[gy][1])
        );
    end

    // stage 2: 1d gradients at the two hashed corners
    gn_ram #(.AW(IW), .DW(16)) u_grad1 (
        .clk     (clk),
        .en      (adv),
        .we      (c2_reg.valid && c2_reg.req_type == REQ_LOAD_G1),
        .waddr   (ti2_reg),
        .wdata   (gr2_reg[0]),
        .raddr_a (pi),
        .raddr_b (pj),
        .rdata_a (g1_rd[0]),
        .rdata_b (g1_rd[1])
    );

    assign zc[0] = zc3_reg;
    assign zc[1] = zc3_reg + IW'(1);

    // stage 3: 2d gradients, one copy per y row
    for (genvar gy = 0; gy < 2; gy++)
    begin : g_grad2
        gn_ram #(.AW(IW), .DW(32)) u_grad2 (
            .clk     (clk),
            .en      (adv),
            .we      (c3_reg.valid && c3_reg.req_type == REQ_LOAD_G2),
            .waddr   (ti3_reg),
            .wdata   ({gr3_reg[0], gr3_reg[1]}),
            .raddr_a (hy[gy][0]),
            .raddr_b (hy[gy][1]),
            .rdata_a (g2[2*gy]),
            .rdata_b (g2[2*gy+1])
        );
    end

    // stage 3: 3d gradients, one copy per (y, z) corner pair
    for (genvar gk = 0; gk < 4; gk++)
    begin : g_grad3
        localparam int YB = gk % 2;
        localparam int ZB = gk / 2;
        gn_ram #(.AW(IW), .DW(48)) u_grad3 (
            .clk     (clk),
            .en      (adv),
            .we      (c3_reg.valid && c3_reg.req_type == REQ_LOAD_G3),
            .waddr   (ti3_reg),
            .wdata   ({gr3_reg[0], gr3_reg[1], gr3_reg[2]}),
            .raddr_a (hy[YB][0] + zc[ZB]),
            .raddr_b (hy[YB][1] + zc[ZB]),
            .rdata_a (g3[2*gk]),
            .rdata_b (g3[2*gk+1])
        );
    end

    assign ctl   = c4_reg;
    assign frac  = fr4_reg;
    assign curve = s4_reg;
    assign g1    = g1_reg;

endmodule

// ===== src/gn_blend.sv =====
// corner dot products and the three interpolation levels
module gn_blend #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  gn_pkg::ctl_t                    ctl,
    input  logic [2:0][COORD_FRAC_BITS-1:0] frac,
    input  logic [2:0][COORD_FRAC_BITS:0]   curve,
    input  logic [1:0][15:0]                g1,
    input  logic [3:0][31:0]                g2,
    input  logic [7:0][47:0]                g3,
    output gn_pkg::ctl_t                    ctl_out,
    output logic signed [gn_pkg::VW-1:0]    value
);
    import gn_pkg::*;

    localparam int F    = COORD_FRAC_BITS;
    localparam int PW   = F + 18;
    localparam int SUMW = PW + 2;
    localparam int MW   = F + VW + 3;

    ctl_t                  ctl_reg [8];
    logic [2:0][F:0]       cur_reg [6];

    logic signed [15:0]    gsel [8][3];
    logic signed [F+1:0]   rsel [8][3];
    logic signed [F+1:0]   r0s [3];
    logic signed [F+1:0]   r1s [3];
    logic [2:0][F:0]       s_eff;

    logic signed [PW-1:0]  p_reg [8][3];
    logic signed [VW-1:0]  dot_reg [8];
    logic signed [VW-1:0]  xa_reg [4];
    logic signed [MW-1:0]  xm_reg [4];
    logic signed [VW-1:0]  lx_reg [4];
    logic signed [VW-1:0]  ya_reg [2];
    logic signed [MW-1:0]  ym_reg [2];
    logic signed [VW-1:0]  ly_reg [2];
    logic signed [VW-1:0]  za_reg;
    logic signed [MW-1:0]  zm_reg;
    logic signed [VW-1:0]  v_reg;

    // s * (b - a), before the shift
    function automatic logic signed [MW-1:0] lmul(input logic [F:0] s,
                                                 input logic signed [VW-1:0] a,
                                                 input logic signed [VW-1:0] b);
        logic signed [VW:0] d;
        d = {b[VW-1], b} - {a[VW-1], a};
        return $signed({1'b0, s}) * d;
    endfunction

    // a + floor(m / 2^F)
    function automatic logic signed [VW-1:0] ladd(input logic signed [VW-1:0] a,
                                                 input logic signed [MW-1:0] m);
        return a + $signed(m[F+VW-1:F]);
    endfunction

    // floor of the gradient dot product
    function automatic logic signed [VW-1:0] dsum(input logic signed [PW-1:0] p0,
                                                 input logic signed [PW-1:0] p1,
                                                 input logic signed [PW-1:0] p2);
        logic signed [SUMW-1:0] t;
        t = SUMW'(p0) + SUMW'(p1) + SUMW'(p2);
        return t[F+VW-1:F];
    endfunction

    // gradient and offset for each of the eight corners
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            r0s[a] = $signed({2'b00, frac[a]});
            r1s[a] = $signed({2'b00, frac[a]}) - $signed({2'b01, {F{1'b0}}});
        end
        s_eff = curve;
        case (ctl.req_type)
            REQ_EVAL1:
            begin
                s_eff[1] = '0;
                s_eff[2] = '0;
            end
            REQ_EVAL2:
            begin
                s_eff[2] = '0;
            end
            default:
            begin
            end
        endcase
        for (int c = 0; c < 8; c++)
        begin
            gsel[c][0] = '0;
            gsel[c][1] = '0;
            gsel[c][2] = '0;
            case (ctl.req_type)
                REQ_EVAL1:
                begin
                    if (c < 2)
                    begin
                        gsel[c][0] = g1[c[0]];
                    end
                end
                REQ_EVAL2:
                begin
                    if (c < 4)
                    begin
                        gsel[c][0] = g2[c[1:0]][31:16];
                        gsel[c][1] = g2[c[1:0]][15:0];
                    end
                end
                REQ_EVAL3:
                begin
                    gsel[c][0] = g3[c[2:0]][47:32];
                    gsel[c][1] = g3[c[2:0]][31:16];
                    gsel[c][2] = g3[c[2:0]][15:0];
                end
                default:
                begin
                end
            endcase
            rsel[c][0] = c[0] ? r1s[0] : r0s[0];
            rsel[c][1] = c[1] ? r1s[1] : r0s[1];
            rsel[c][2] = c[2] ? r1s[2] : r0s[2];
        end
    end

    // control line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 8; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            ctl_reg[0] <= ctl;
            for (int k = 1; k < 8; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // arithmetic line
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // products
            cur_reg[0] <= s_eff;
            for (int c = 0; c < 8; c++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    p_reg[c][a] <= gsel[c][a] * rsel[c][a];
                end
            end
            for (int k = 1; k < 6; k++)
            begin
                cur_reg[k] <= cur_reg[k-1];
            end
            // dots
            for (int c = 0; c < 8; c++)
            begin
                dot_reg[c] <= dsum(p_reg[c][0], p_reg[c][1], p_reg[c][2]);
            end
            // x level
            for (int k = 0; k < 4; k++)
            begin
                xa_reg[k] <= dot_reg[2*k];
                xm_reg[k] <= lmul(cur_reg[1][0], dot_reg[2*k], dot_reg[2*k+1]);
                lx_reg[k] <= ladd(xa_reg[k], xm_reg[k]);
            end
            // y level
            for (int k = 0; k < 2; k++)
            begin
                ya_reg[k] <= lx_reg[2*k];
                ym_reg[k] <= lmul(cur_reg[3][1], lx_reg[2*k], lx_reg[2*k+1]);
                ly_reg[k] <= ladd(ya_reg[k], ym_reg[k]);
            end
            // z level
            za_reg <= ly_reg[0];
            zm_reg <= lmul(cur_reg[5][2], ly_reg[0], ly_reg[1]);
            v_reg  <= ladd(za_reg, zm_reg);
        end
    end

    assign ctl_out = ctl_reg[7];
    assign value   = v_reg;

endmodule

// ===== src/gn_checker.sv =====
// port-level checks for the gradient noise unit, bound to the top level
module gn_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input gn_pkg::in_word_t  req_word,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input gn_pkg::out_word_t rsp_word
);

    // a held result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped while stalled");

    // intake is only blocked by a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stalled without a held result");

    // load acknowledges carry zero
    a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_word.is_noise |-> rsp_word.noise_value == 16'sd0)
        else $error("load acknowledge with nonzero value");

    // a free output accepts a request in the same cycle
    a_free_take: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("request stalled with empty output");

endmodule

bind gradient_noise_1d_2d_3d_unit gn_checker u_gn_checker (.*);

// ===== test/tb_gradient_noise_1d_2d_3d_unit.sv =====
// testbench for the gradient noise unit: table loads, directed and random noise checks
`timescale 1ns / 100ps

module tb_gradient_noise_1d_2d_3d_unit;

    import gn_pkg::*;

    // request code that the block must ignore
    localparam logic [2:0] REQ_UNUSED = 3'd7;
    localparam int         LATENCY    = 13;

    typedef struct {
        longint b0, b1, r0, r1, s;
    } lattice_t;

    typedef struct {
        in_word_t  w;
        bit        has_exp;
        out_word_t e;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    in_word_t  req_word;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    out_word_t rsp_word;

    // predictor copy of the lookup tables
    logic [7:0]         perm_tab [256];
    logic signed [15:0] g1_tab   [256];
    logic signed [15:0] g2x_tab  [256];
    logic signed [15:0] g2y_tab  [256];
    logic signed [15:0] g3x_tab  [256];
    logic signed [15:0] g3y_tab  [256];
    logic signed [15:0] g3z_tab  [256];

    out_word_t noise_q[$];
    dir_row_t  dir_rows[$];
    int        fail_count;
    bit        idle_on;

    gradient_noise_1d_2d_3d_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // cell index, fraction and fade weight for one axis
    function automatic lattice_t lattice(logic signed [31:0] c);
        lattice_t a;
        longint   cell_num;
        longint   q;
        cell_num = longint'(c) >>> 16;
        a.b0 = cell_num & 255;
        a.b1 = (cell_num + 1) & 255;
        a.r0 = longint'(c[15:0]);
        a.r1 = a.r0 - 65536;
        q    = (a.r0 * a.r0) >>> 16;
        a.s  = (q * (3 * 65536 - 2 * a.r0)) >>> 16;
        return a;
    endfunction

    function automatic longint blend(longint s, longint a, longint b);
        return a + ((s * (b - a)) >>> 16);
    endfunction

    function automatic longint hash(longint i);
        return longint'(perm_tab[i & 255]);
    endfunction

    function automatic longint dot2(longint k, longint rx, longint ry);
        k = k & 255;
        return (longint'(g2x_tab[k]) * rx + longint'(g2y_tab[k]) * ry) >>> 16;
    endfunction

    function automatic longint dot3(longint k, longint rx, longint ry, longint rz);
        k = k & 255;
        return (longint'(g3x_tab[k]) * rx + longint'(g3y_tab[k]) * ry
                + longint'(g3z_tab[k]) * rz) >>> 16;
    endfunction

    // table writes and noise prediction for one accepted word
    function automatic out_word_t noise_of(in_word_t w);
        out_word_t o;
        lattice_t  x, y, z;
        longint    i, j, b00, b10, b01, b11, a, b, c, d, v;
        o = '0;
        v = 0;
        x = lattice(w.coord_x);
        y = lattice(w.coord_y);
        z = lattice(w.coord_z);
        case (w.req_type)
            REQ_LOAD_PERM: perm_tab[w.table_index] = w.perm_value;
            REQ_LOAD_G1:   g1_tab[w.table_index] = w.grad_x;
            REQ_LOAD_G2:
            begin
                g2x_tab[w.table_index] = w.grad_x;
                g2y_tab[w.table_index] = w.grad_y;
            end
            REQ_LOAD_G3:
            begin
                g3x_tab[w.table_index] = w.grad_x;
                g3y_tab[w.table_index] = w.grad_y;
                g3z_tab[w.table_index] = w.grad_z;
            end
            REQ_EVAL1:
            begin
                a = (x.r0 * longint'(g1_tab[hash(x.b0)])) >>> 16;
                b = (x.r1 * longint'(g1_tab[hash(x.b1)])) >>> 16;
                v = blend(x.s, a, b);
                o.is_noise = 1'b1;
            end
            REQ_EVAL2, REQ_EVAL3:
            begin
                i   = hash(x.b0);
                j   = hash(x.b1);
                b00 = hash(i + y.b0);
                b10 = hash(j + y.b0);
                b01 = hash(i + y.b1);
                b11 = hash(j + y.b1);
                if (w.req_type == REQ_EVAL2)
                begin
                    a = blend(x.s, dot2(b00, x.r0, y.r0), dot2(b10, x.r1, y.r0));
                    b = blend(x.s, dot2(b01, x.r0, y.r1), dot2(b11, x.r1, y.r1));
                    v = blend(y.s, a, b);
                end
                else
                begin
                    a = blend(x.s, dot3(b00 + z.b0, x.r0, y.r0, z.r0),
                              dot3(b10 + z.b0, x.r1, y.r0, z.r0));
                    b = blend(x.s, dot3(b01 + z.b0, x.r0, y.r1, z.r0),
                              dot3(b11 + z.b0, x.r1, y.r1, z.r0));
                    c = blend(y.s, a, b);
                    a = blend(x.s, dot3(b00 + z.b1, x.r0, y.r0, z.r1),
                              dot3(b10 + z.b1, x.r1, y.r0, z.r1));
                    b = blend(x.s, dot3(b01 + z.b1, x.r0, y.r1, z.r1),
                              dot3(b11 + z.b1, x.r1, y.r1, z.r1));
                    d = blend(y.s, a, b);
                    v = blend(z.s, c, d);
                end
                o.is_noise = 1'b1;
            end
            default: ;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        o.noise_value = 16'(v);
        return o;
    endfunction

    function automatic logic signed [15:0] rand_grad();
        int t;
        t = $urandom_range(32768);
        return 16'(t - 16384);
    endfunction

    function automatic in_word_t make_word(logic [2:0] rq, logic [7:0] idx, logic [7:0] pv,
                                           logic signed [15:0] gx, logic signed [15:0] gy,
                                           logic signed [15:0] gz, logic signed [31:0] cx,
                                           logic signed [31:0] cy, logic signed [31:0] cz);
        in_word_t w;
        w = '{rq, idx, pv, gx, gy, gz, cx, cy, cz};
        return w;
    endfunction

    function automatic in_word_t rand_word(logic [2:0] rq);
        return make_word(rq, 8'($urandom), 8'($urandom), rand_grad(), rand_grad(),
                         rand_grad(), $urandom, $urandom, $urandom);
    endfunction

    // send one word and record its expectation when accepted
    task automatic send_word(in_word_t w, bit has_exp, out_word_t e);
        out_word_t p;
        while (idle_on && $urandom_range(99) < 19)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        do
            @(posedge clk);
        while (req_stall);
        p = noise_of(w);
        noise_q.push_back(has_exp ? e : p);
        @(negedge clk);
    endtask

    task automatic add_row(in_word_t w, bit has_exp, out_word_t e);
        dir_row_t r;
        r.w       = w;
        r.has_exp = has_exp;
        r.e       = e;
        dir_rows.push_back(r);
    endtask

    // receiver stall
    always @(negedge clk)
        rsp_stall <= idle_on && ($urandom_range(99) < 19);

    // result checker
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (noise_q.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                e = noise_q.pop_front();
                if (rsp_word.noise_value !== e.noise_value)
                begin
                    $error("noise_value expected %0d got %0d", e.noise_value,
                           rsp_word.noise_value);
                    fail_count++;
                end
                if (rsp_word.is_noise !== e.is_noise)
                begin
                    $error("is_noise expected %0d got %0d", e.is_noise, rsp_word.is_noise);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // stimulus
    initial
    begin
        out_word_t ack, zero_eval;
        int        n;
        ack        = '0;
        zero_eval  = '{16'sd0, 1'b1};
        fail_count = 0;
        idle_on    = 1'b1;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_word   = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill every table entry before any evaluation reads it
        for (int k = 0; k < 256; k++)
            for (int t = 0; t < 4; t++)
            begin
                in_word_t w;
                w = rand_word(3'(t));
                w.table_index = 8'(k);
                send_word(w, 1'b0, ack);
            end

        // directed words
        add_row(make_word(REQ_LOAD_PERM, 8'd0, 8'd255, 0, 0, 0, 0, 0, 0), 1, ack);
        add_row(make_word(REQ_LOAD_PERM, 8'd255, 8'd0, 0, 0, 0, 0, 0, 0), 1, ack);
        add_row(make_word(REQ_LOAD_G1, 8'd255, 0, 16384, 0, 0, 0, 0, 0), 1, ack);
        add_row(make_word(REQ_LOAD_G1, 8'd0, 0, -16384, 0, 0, 0, 0, 0), 1, ack);
        add_row(make_word(REQ_LOAD_G2, 8'd128, 0, -16384, 16384, 0, 0, 0, 0), 1, ack);
        add_row(make_word(REQ_LOAD_G3, 8'd1, 0, 16384, -16384, 16384, 0, 0, 0), 1, ack);
        add_row(make_word(REQ_LOAD_G3, 8'd0, 0, -16384, -16384, -16384, 0, 0, 0), 1, ack);
        add_row(make_word(REQ_UNUSED, '1, '1, -1, -1, -1, -1, -1, -1), 1, ack);
        add_row(make_word(REQ_EVAL1, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_eval);
        add_row(make_word(REQ_EVAL1, 0, 0, 0, 0, 0, 32'h7fffffff, 0, 0), 0, ack);
        add_row(make_word(REQ_EVAL1, 0, 0, 0, 0, 0, 32'h80000000, 0, 0), 0, ack);
        add_row(make_word(REQ_EVAL1, 0, 0, 0, 0, 0, -1, 0, 0), 0, ack);
        add_row(make_word(REQ_EVAL1, 0, 0, 0, 0, 0, 32'h00ff8000, 0, 0), 0, ack);
        add_row(make_word(REQ_EVAL2, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 0), 0, ack);
        add_row(make_word(REQ_EVAL2, 0, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 0), 0, ack);
        add_row(make_word(REQ_EVAL2, 0, 0, 0, 0, 0, 0, -65536, 0), 0, ack);
        add_row(make_word(REQ_EVAL2, 0, 0, 0, 0, 0, 32'h00ff8000, 32'hffff4000, 0), 0, ack);
        add_row(make_word(REQ_EVAL3, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff), 0, ack);
        add_row(make_word(REQ_EVAL3, 0, 0, 0, 0, 0, 32'h80000000, 32'h80000000,
                          32'h80000000), 0, ack);
        add_row(make_word(REQ_EVAL3, 0, 0, 0, 0, 0, 32'h00ff8000, -1, 32'h00008000), 0, ack);
        add_row(make_word(REQ_EVAL3, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_eval);
        foreach (dir_rows[k])
            send_word(dir_rows[k].w, dir_rows[k].has_exp, dir_rows[k].e);

        // hold off until the pipeline has drained
        req_valid <= 1'b0;
        while (noise_q.size() != 0)
            @(negedge clk);

        // random words, with a stretch of back-to-back traffic in the middle
        for (int k = 0; k < 910; k++)
        begin
            idle_on = !(k >= 300 && k < 500);
            n = $urandom_range(99);
            if (n < 75)
                send_word(rand_word(3'($urandom_range(REQ_EVAL3, REQ_EVAL1))), 0, ack);
            else if (n < 95)
                send_word(rand_word(3'($urandom_range(REQ_LOAD_G3, REQ_LOAD_PERM))), 0, ack);
            else
                send_word(rand_word(REQ_UNUSED), 0, ack);
        end

        // drain and finish
        req_valid <= 1'b0;
        while (noise_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/gn_pkg.sv
src/gn_ram.sv
src/gn_lookup.sv
src/gn_blend.sv
src/gradient_noise_1d_2d_3d_unit.sv
src/gn_checker.sv
test/tb_gradient_noise_1d_2d_3d_unit.sv
